// File: hdl/bq_pkg.sv
// Shared types, constants and microcode program for the biquad filter.
package bq_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 32;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int STEP_BITS       = 3;

  typedef logic [STEP_BITS-1:0] step_t;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_ONE = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_TWO = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FORWARD_ZERO = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FORWARD_ONE  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FORWARD_TWO  = 3'd4;

  // Program addresses.
  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_FB_TWO = 3'd1;
  localparam step_t STEP_W      = 3'd2;
  localparam step_t STEP_FF_ZERO = 3'd3;
  localparam step_t STEP_FF_TWO = 3'd4;
  localparam step_t STEP_FINISH = 3'd5;

  typedef enum logic [2:0] {
    COEF_FB_ONE,
    COEF_FB_TWO,
    COEF_FF_ZERO,
    COEF_FF_ONE,
    COEF_FF_TWO
  } coef_sel_t;

  typedef enum logic [1:0] {
    DATA_FIRST,
    DATA_SECOND,
    DATA_W
  } data_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_START,
    JMP_OUT
  } jump_t;

  typedef struct packed {
    logic      take_in;
    coef_sel_t coef_sel;
    data_sel_t data_sel;
    logic      mul_en;
    acc_op_t   acc_op;
    logic      w_en;
    logic      finish;
    jump_t     jump;
    step_t     target;
  } uword_t;

  typedef struct packed {
    logic in_fire;
    logic load_op;
    logic out_free;
  } status_t;

  // One control word per step. The product register holds the term that the
  // accumulator rounds and adds in the following step.
  function automatic uword_t micro_word(step_t step);
    uword_t u;
    u = '{take_in: 1'b0, coef_sel: COEF_FB_ONE, data_sel: DATA_FIRST, mul_en: 1'b0,
          acc_op: ACC_HOLD, w_en: 1'b0, finish: 1'b0, jump: JMP_OUT, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        u.take_in = 1'b1;
        u.coef_sel = COEF_FB_ONE;
        u.data_sel = DATA_FIRST;
        u.mul_en = 1'b1;
        u.jump = JMP_START;
      end
      STEP_FB_TWO: begin
        u.coef_sel = COEF_FB_TWO;
        u.data_sel = DATA_SECOND;
        u.mul_en = 1'b1;
        u.acc_op = ACC_LOAD_X;
        u.jump = JMP_NEXT;
      end
      STEP_W: begin
        u.coef_sel = COEF_FF_ONE;
        u.data_sel = DATA_FIRST;
        u.mul_en = 1'b1;
        u.w_en = 1'b1;
        u.jump = JMP_NEXT;
      end
      STEP_FF_ZERO: begin
        u.coef_sel = COEF_FF_ZERO;
        u.data_sel = DATA_W;
        u.mul_en = 1'b1;
        u.acc_op = ACC_LOAD;
        u.jump = JMP_NEXT;
      end
      STEP_FF_TWO: begin
        u.coef_sel = COEF_FF_TWO;
        u.data_sel = DATA_SECOND;
        u.mul_en = 1'b1;
        u.acc_op = ACC_ADD;
        u.jump = JMP_NEXT;
      end
      STEP_FINISH: begin
        u.finish = 1'b1;
        u.jump = JMP_OUT;
        u.target = STEP_IDLE;
      end
      default: begin
        u.jump = JMP_OUT;
        u.target = STEP_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

// File: hdl/bq_seq.sv
// Step counter and microcode table for the biquad filter.
module bq_seq (
  input  logic            clk,
  input  logic            rst,
  input  bq_pkg::status_t status,
  output bq_pkg::uword_t  ctrl
);

  bq_pkg::step_t  step;
  bq_pkg::step_t  step_next;
  bq_pkg::uword_t word;

  always_comb begin
    word = bq_pkg::micro_word(step);
    ctrl = word;
    // The last step waits until the output register can take the word.
    ctrl.finish = word.finish & status.out_free;
    step_next = step;
    case (word.jump)
      bq_pkg::JMP_NEXT:  step_next = step + 1'b1;
      bq_pkg::JMP_START: if (status.in_fire && !status.load_op) step_next = step + 1'b1;
      bq_pkg::JMP_OUT:   if (status.out_free) step_next = word.target;
      default:           step_next = bq_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= bq_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// File: hdl/bq_datapath.sv
// Coefficients, delay words, shared multiplier and accumulator of the biquad filter.
module bq_datapath #(
  parameter int SAMPLE_BITS = bq_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = bq_pkg::COEF_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bq_pkg::uword_t                      ctrl,
  input  logic                                cfg_write,
  input  logic [bq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [COEF_BITS-1:0]                cfg_data,
  input  logic                                in_fire,
  input  logic                                operation,
  input  logic [SAMPLE_BITS-1:0]              sample_in,
  input  logic [SAMPLE_BITS+7:0]              load_first,
  input  logic [SAMPLE_BITS+7:0]              load_second,
  output logic [SAMPLE_BITS-1:0]              sample_out
);

  localparam int SW = SAMPLE_BITS + 8;
  localparam int PW = COEF_BITS + SW;
  localparam int CF = COEF_BITS - 4;
  localparam int RW = PW - CF;
  localparam int AW = RW + 2;
  localparam logic signed [PW-1:0] HALF = {{(PW-CF){1'b0}}, 1'b1, {(CF-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [COEF_BITS-1:0] fb_one, fb_two, ff_zero, ff_one, ff_two;
  logic signed [SW-1:0]        d_first, d_second, w;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [PW-1:0]        prod;
  logic signed [AW-1:0]        acc;

  logic signed [COEF_BITS-1:0] mul_a;
  logic signed [SW-1:0]        mul_b;
  logic signed [PW-1:0]        prod_half;
  logic signed [RW-1:0]        rnd;
  logic signed [AW-1:0]        rnd_ext;
  logic signed [AW-1:0]        x_ext;
  logic signed [AW-1:0]        acc_sum;
  logic                        w_fits;
  logic                        out_fits;
  logic [SW-1:0]               w_next;
  logic [SAMPLE_BITS-1:0]      y_sat;

  always_comb begin
    case (ctrl.coef_sel)
      bq_pkg::COEF_FB_ONE:  mul_a = fb_one;
      bq_pkg::COEF_FB_TWO:  mul_a = fb_two;
      bq_pkg::COEF_FF_ZERO: mul_a = ff_zero;
      bq_pkg::COEF_FF_ONE:  mul_a = ff_one;
      bq_pkg::COEF_FF_TWO:  mul_a = ff_two;
      default:              mul_a = fb_one;
    endcase
    case (ctrl.data_sel)
      bq_pkg::DATA_FIRST:  mul_b = d_first;
      bq_pkg::DATA_SECOND: mul_b = d_second;
      bq_pkg::DATA_W:      mul_b = w;
      default:             mul_b = d_first;
    endcase
  end

  // Round half up to the sample fraction; the product never reaches the top
  // bit, so adding the half cannot overflow.
  assign prod_half = prod + HALF;
  assign rnd       = prod_half[PW-1:CF];
  assign rnd_ext   = {{2{rnd[RW-1]}}, rnd};
  assign x_ext     = {{(AW-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
  assign acc_sum   = acc + rnd_ext;

  assign w_fits   = (&acc_sum[AW-1:SW-1]) | ~(|acc_sum[AW-1:SW-1]);
  assign w_next   = w_fits ? acc_sum[SW-1:0] : '0;
  assign out_fits = (&acc_sum[AW-1:SAMPLE_BITS-1]) | ~(|acc_sum[AW-1:SAMPLE_BITS-1]);
  assign y_sat    = out_fits ? acc_sum[SAMPLE_BITS-1:0]
                             : (acc_sum[AW-1] ? OUT_MIN : OUT_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_one   <= '0;
      fb_two   <= '0;
      ff_zero  <= '0;
      ff_one   <= '0;
      ff_two   <= '0;
      d_first  <= '0;
      d_second <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          bq_pkg::REG_FEEDBACK_ONE: fb_one  <= cfg_data;
          bq_pkg::REG_FEEDBACK_TWO: fb_two  <= cfg_data;
          bq_pkg::REG_FORWARD_ZERO: ff_zero <= cfg_data;
          bq_pkg::REG_FORWARD_ONE:  ff_one  <= cfg_data;
          bq_pkg::REG_FORWARD_TWO:  ff_two  <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire && operation) begin
        d_first  <= load_first;
        d_second <= load_second;
      end else if (ctrl.finish) begin
        d_second <= d_first;
        d_first  <= w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !operation) begin
      x <= sample_in;
    end
    if (ctrl.mul_en) begin
      prod <= PW'(mul_a) * PW'(mul_b);
    end
    case (ctrl.acc_op)
      bq_pkg::ACC_LOAD_X: acc <= x_ext + rnd_ext;
      bq_pkg::ACC_LOAD:   acc <= rnd_ext;
      bq_pkg::ACC_ADD:    acc <= acc_sum;
      default:            acc <= acc;
    endcase
    if (ctrl.w_en) begin
      w <= w_next;
    end
    if (ctrl.finish) begin
      sample_out <= y_sat;
    end
  end

endmodule

// File: hdl/biquad_iir_filter.sv
// Top level of the microcoded direct form II biquad filter.
//
//   channel | signals                                          | word
//   --------+--------------------------------------------------+-----------------------
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data        | one coefficient write
//   in      | in_valid, in_ready, operation, sample_in,        | one filter or load
//           | load_first, load_second                          | request
//   out     | out_valid, out_ready, sample_out                 | one filtered sample
//
// A filter word runs through the program steps from acceptance to the next
// acceptance: five products go one after another through the single multiplier,
// each followed by a rounding add into the accumulator. A load word is accepted
// on the idle step, leaves the sequencer there and gives no output. Reset clears
// coefficients and delay words. A full output register holds the sequencer on its
// last step until out_ready frees it; configuration writes are always taken.
module biquad_iir_filter #(
  parameter int SAMPLE_BITS = bq_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = bq_pkg::COEF_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bq_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COEF_BITS-1:0]              cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              operation,
  input  logic [SAMPLE_BITS-1:0]            sample_in,
  input  logic [SAMPLE_BITS+7:0]            load_first,
  input  logic [SAMPLE_BITS+7:0]            load_second,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [SAMPLE_BITS-1:0]            sample_out
);

  bq_pkg::uword_t  ctrl;
  bq_pkg::status_t status;
  logic            in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = ctrl.take_in;
  assign in_fire   = in_valid & in_ready;

  assign status.in_fire  = in_fire;
  assign status.load_op  = operation;
  assign status.out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  bq_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  bq_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .cfg_write   (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_fire     (in_fire),
    .operation   (operation),
    .sample_in   (sample_in),
    .load_first  (load_first),
    .load_second (load_second),
    .sample_out  (sample_out)
  );

endmodule
